[rtl/wbss_pkg.sv]
package wbss_pkg;

  // Pattern storage and history window sizes
  localparam int MAX_PATTERN   = 16;
  localparam int HISTORY_DEPTH = 64;

  // Usable pattern length is limited by the two 64-bit pattern registers
  localparam int PAT_CAP    = (MAX_PATTERN < 16) ? MAX_PATTERN : 16;
  localparam int PAT_IDX_W  = (PAT_CAP > 1) ? $clog2(PAT_CAP) : 1;
  localparam int LEN_W      = 5;
  localparam int HIST_IDX_W = $clog2(HISTORY_DEPTH);
  localparam int FILL_W     = $clog2(HISTORY_DEPTH + 1);

  // A call instruction is one opcode byte plus a 32-bit displacement
  localparam int CALL_LEN   = 5;
  localparam int DISP_BYTES = 4;

  // Queue between the match front end and the address back end
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_WILDCARD_MASK  = 3'd2,
    REG_PATTERN_LENGTH = 3'd3,
    REG_TARGET_OFFSET  = 3'd4,
    REG_RESOLVE_CALL   = 3'd5,
    REG_FIND_ALL       = 3'd6,
    REG_MAX_MATCHES    = 3'd7
  } reg_index_t;

  // Input kind codes
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  // Configuration register file contents
  typedef struct packed {
    logic [63:0]        pattern_low;
    logic [63:0]        pattern_high;
    logic [15:0]        wildcard_mask;
    logic [LEN_W-1:0]   pattern_length;
    logic signed [15:0] target_offset;
    logic               resolve_call;
    logic               find_all;
    logic [15:0]        max_matches;
  } cfg_t;

  // One match as handed from the front end to the back end
  typedef struct packed {
    logic [31:0] start_addr;
    logic        disp_miss;
    logic [31:0] disp;
    logic [15:0] match_number;
    logic        search_done;
  } hit_t;

  // Clamp the programmed length into 1..PAT_CAP
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] n;
    n = len;
    if (n == '0) begin
      n = LEN_W'(1);
    end else if (n > LEN_W'(PAT_CAP)) begin
      n = LEN_W'(PAT_CAP);
    end
    return n;
  endfunction

endpackage

[rtl/wbss_front.sv]
module wbss_front (
  input  logic              clk,
  input  logic              rst_n,
  input  wbss_pkg::cfg_t    cfg,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_kind,
  input  logic [7:0]        in_data_byte,
  input  logic [31:0]       in_byte_address,
  input  logic              in_region_last,
  input  logic              fifo_full,
  output logic              push,
  output wbss_pkg::hit_t    push_data
);

  logic [7:0]                  hist_r [wbss_pkg::HISTORY_DEPTH];
  logic [7:0]                  hist_sh [wbss_pkg::HISTORY_DEPTH];
  logic [wbss_pkg::FILL_W-1:0] fill_r, fill_nxt, fill_inc;
  logic [wbss_pkg::LEN_W-1:0]  elig_r, elig_nxt, elig_inc;
  logic [15:0]                 count_r, count_nxt, count_inc;
  logic                        done_r, done_nxt, done_set;
  logic [wbss_pkg::LEN_W-1:0]  len;
  logic [127:0]                pat_all;
  logic                        accept;
  logic                        take_byte;
  logic                        mismatch;
  logic                        hit;
  logic [31:0]                 disp;
  logic                        disp_miss;

  assign in_tready = !fifo_full;
  assign accept    = in_tvalid && in_tready;
  assign take_byte = accept && (in_kind == wbss_pkg::KIND_BYTE) && !done_r;
  assign len       = wbss_pkg::eff_len(cfg.pattern_length);
  assign pat_all   = {cfg.pattern_high, cfg.pattern_low};

  // Window as it stands once the incoming byte is shifted in
  always_comb begin
    hist_sh[0] = in_data_byte;
    for (int j = 1; j < wbss_pkg::HISTORY_DEPTH; j++) begin
      hist_sh[j] = hist_r[j-1];
    end
  end

  // Saturating fills
  assign fill_inc = (fill_r < wbss_pkg::FILL_W'(wbss_pkg::HISTORY_DEPTH)) ?
                    fill_r + 1'b1 : fill_r;
  assign elig_inc = (elig_r < len) ? elig_r + 1'b1 : elig_r;

  // Masked compare of every pattern byte against the newest window bytes
  always_comb begin
    logic [wbss_pkg::LEN_W-1:0] idx;
    mismatch = 1'b0;
    for (int i = 0; i < wbss_pkg::PAT_CAP; i++) begin
      idx = len - 1'b1 - wbss_pkg::LEN_W'(i);
      if ((wbss_pkg::LEN_W'(i) < len) && !cfg.wildcard_mask[i] &&
          (hist_sh[wbss_pkg::HIST_IDX_W'(idx)] != pat_all[i*8 +: 8])) begin
        mismatch = 1'b1;
      end
    end
  end

  assign hit = (elig_inc >= len) && !mismatch;

  // Displacement bytes sit at fixed window distances set by length and offset
  always_comb begin
    logic [31:0] back;
    disp      = '0;
    disp_miss = 1'b0;
    for (int k = 0; k < wbss_pkg::DISP_BYTES; k++) begin
      back = 32'(len) - 32'd2 - {{16{cfg.target_offset[15]}}, cfg.target_offset} - 32'(k);
      if (back >= 32'(fill_inc)) begin
        disp_miss = 1'b1;
      end
      disp[k*8 +: 8] = hist_sh[back[wbss_pkg::HIST_IDX_W-1:0]];
    end
  end

  // Match counting and search end
  assign count_inc = count_r + 1'b1;
  assign done_set  = !cfg.find_all || (count_inc >= cfg.max_matches);

  always_comb begin
    fill_nxt  = fill_r;
    elig_nxt  = elig_r;
    count_nxt = count_r;
    done_nxt  = done_r;
    push      = 1'b0;
    if (accept && (in_kind == wbss_pkg::KIND_RESTART)) begin
      fill_nxt  = '0;
      elig_nxt  = '0;
      count_nxt = '0;
      done_nxt  = 1'b0;
    end else if (take_byte) begin
      fill_nxt = in_region_last ? '0 : fill_inc;
      elig_nxt = (in_region_last || hit) ? '0 : elig_inc;
      if (hit) begin
        count_nxt = count_inc;
        done_nxt  = done_set;
        push      = 1'b1;
      end
    end
  end

  // Word handed to the queue
  always_comb begin
    push_data.start_addr   = in_byte_address - 32'(len - 1'b1);
    push_data.disp_miss    = disp_miss;
    push_data.disp         = disp;
    push_data.match_number = count_inc;
    push_data.search_done  = done_set;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      elig_r  <= '0;
      count_r <= '0;
      done_r  <= 1'b0;
    end else begin
      fill_r  <= fill_nxt;
      elig_r  <= elig_nxt;
      count_r <= count_nxt;
      done_r  <= done_nxt;
    end
  end

  // History shift line; bytes beyond the fill count are never used
  always_ff @(posedge clk) begin
    if (take_byte) begin
      hist_r <= hist_sh;
    end
  end

endmodule

[rtl/wbss_fifo.sv]
module wbss_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  wbss_pkg::hit_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output wbss_pkg::hit_t pop_data
);

  wbss_pkg::hit_t                  mem_r [wbss_pkg::FIFO_DEPTH];
  logic [wbss_pkg::FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [wbss_pkg::FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [wbss_pkg::FIFO_CNT_W-1:0] count_r, count_nxt;
  logic                            do_pop;

  assign full     = (count_r == wbss_pkg::FIFO_CNT_W'(wbss_pkg::FIFO_DEPTH));
  assign valid    = (count_r != '0);
  assign do_pop   = pop && valid;
  assign pop_data = mem_r[rd_ptr_r];

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == wbss_pkg::FIFO_PTR_W'(wbss_pkg::FIFO_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == wbss_pkg::FIFO_PTR_W'(wbss_pkg::FIFO_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/wbss_back.sv]
module wbss_back (
  input  logic           clk,
  input  logic           rst_n,
  input  wbss_pkg::cfg_t cfg,
  input  logic           fifo_valid,
  input  wbss_pkg::hit_t fifo_data,
  output logic           pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [31:0]    out_found_address,
  output logic           out_status,
  output logic [15:0]    out_match_number,
  output logic           out_search_done
);

  logic        valid_r, valid_nxt;
  logic [31:0] found_r;
  logic        status_r;
  logic [15:0] number_r;
  logic        done_r;
  logic [31:0] base_addr;
  logic [31:0] call_addr;
  logic        resolved;

  assign pop = fifo_valid && (!valid_r || out_tready);

  // Reported address: offset start, or the decoded call target
  assign base_addr = fifo_data.start_addr +
                     {{16{cfg.target_offset[15]}}, cfg.target_offset};
  assign call_addr = base_addr + 32'(wbss_pkg::CALL_LEN) + fifo_data.disp;
  assign resolved  = cfg.resolve_call && !fifo_data.disp_miss;

  always_comb begin
    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (pop) begin
      found_r  <= resolved ? call_addr : base_addr;
      status_r <= cfg.resolve_call && fifo_data.disp_miss;
      number_r <= fifo_data.match_number;
      done_r   <= fifo_data.search_done;
    end
  end

  assign out_tvalid        = valid_r;
  assign out_found_address = found_r;
  assign out_status        = status_r;
  assign out_match_number  = number_r;
  assign out_search_done   = done_r;

endmodule

[rtl/wildcard_byte_signature_scan_unit.sv]
// With the queue empty, a matching byte's result word is written into the queue when the byte
// is taken, then into the output register, and then shows on out_tvalid.
// Throughput: one input word per cycle while in_tready is high; the full pattern is compared to
// the shifted window as a byte is taken; results leave one per cycle while out_tready is high.
// Stalls: in_tready drops only while two match words wait in the queue behind a held output.
// Reset (rst_n low, synchronous) clears search state, queue and output valid, and loads defaults.
module wildcard_byte_signature_scan_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] data_byte, [39:8] byte_address
  input  logic        in_tuser,   // [0] kind
  input  logic        in_tlast,
  // Result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] found_address, [47:32] match_number
  output logic        out_tuser,  // [0] status
  output logic        out_tlast,
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  wbss_pkg::cfg_t cfg_r;
  wbss_pkg::hit_t push_data;
  wbss_pkg::hit_t fifo_data;
  logic           push;
  logic           fifo_full;
  logic           fifo_valid;
  logic           pop;
  logic [31:0]    found_address;
  logic [15:0]    match_number;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_low    <= '0;
      cfg_r.pattern_high   <= '0;
      cfg_r.wildcard_mask  <= '0;
      cfg_r.pattern_length <= wbss_pkg::LEN_W'(1);
      cfg_r.target_offset  <= '0;
      cfg_r.resolve_call   <= 1'b0;
      cfg_r.find_all       <= 1'b0;
      cfg_r.max_matches    <= 16'd32;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wbss_pkg::REG_PATTERN_LOW:    cfg_r.pattern_low    <= cfg_data;
        wbss_pkg::REG_PATTERN_HIGH:   cfg_r.pattern_high   <= cfg_data;
        wbss_pkg::REG_WILDCARD_MASK:  cfg_r.wildcard_mask  <= cfg_data[15:0];
        wbss_pkg::REG_PATTERN_LENGTH: cfg_r.pattern_length <= cfg_data[wbss_pkg::LEN_W-1:0];
        wbss_pkg::REG_TARGET_OFFSET:  cfg_r.target_offset  <= cfg_data[15:0];
        wbss_pkg::REG_RESOLVE_CALL:   cfg_r.resolve_call   <= cfg_data[0];
        wbss_pkg::REG_FIND_ALL:       cfg_r.find_all       <= cfg_data[0];
        wbss_pkg::REG_MAX_MATCHES:    cfg_r.max_matches    <= cfg_data[15:0];
      endcase
    end
  end

  // Front end: window, compare, match count
  wbss_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_kind         (in_tuser),
    .in_data_byte    (in_tdata[7:0]),
    .in_byte_address (in_tdata[39:8]),
    .in_region_last  (in_tlast),
    .fifo_full       (fifo_full),
    .push            (push),
    .push_data       (push_data)
  );

  // Match queue
  wbss_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (pop),
    .valid     (fifo_valid),
    .pop_data  (fifo_data)
  );

  // Back end: address arithmetic and output register
  wbss_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .fifo_valid        (fifo_valid),
    .fifo_data         (fifo_data),
    .pop               (pop),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .out_found_address (found_address),
    .out_status        (out_tuser),
    .out_match_number  (match_number),
    .out_search_done   (out_tlast)
  );

  assign out_tdata = {match_number, found_address};

endmodule

[rtl/wbss_checker.sv]
module wbss_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // A stalled result word keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // Reset empties the output register
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Reset empties the queue, so the input side is open
  a_reset_in: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

  // The running match count never reports zero
  a_match_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[47:32] != 16'd0)
    else $error("match number is zero");

endmodule

bind wildcard_byte_signature_scan_unit wbss_checker u_wbss_checker (.*);
